// ===== rtl/vde_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and character helpers for the designator id extractor.
// No dependencies; RTL files use scoped names, the testbench imports it.
package vde_pkg;

    localparam int MAX_RES     = 5;
    localparam int CNT_W       = $clog2(MAX_RES + 1);
    localparam int CMD_Q_DEPTH = 4;

    // result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_CUT  = 2'd2;

    // identifier types
    localparam logic [1:0] ID_T10  = 2'd0;
    localparam logic [1:0] ID_EUI  = 2'd1;
    localparam logic [1:0] ID_NAA  = 2'd2;
    localparam logic [1:0] ID_NAME = 2'd3;

    // designator codes
    localparam logic [3:0] DC_T10  = 4'h1;
    localparam logic [3:0] DC_EUI  = 4'h2;
    localparam logic [3:0] DC_NAA  = 4'h3;
    localparam logic [3:0] DC_NAME = 4'h8;

    // walk positions
    localparam logic [2:0] HDR_LEN     = 3'd4;
    localparam logic [2:0] POS_CODE    = 3'd1;
    localparam logic [2:0] POS_LEN     = 3'd3;
    localparam logic [2:0] POS_PAYLOAD = 3'd4;
    localparam logic [2:0] PREFIX_LEN  = 3'd4;

    typedef struct packed {
        logic [7:0] page_byte;
        logic       page_end;
    } t_page_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_char;
        logic [1:0] id_type;
        logic       run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] text_char;
        logic [1:0] id_type;
    } t_slot;

    typedef t_slot [MAX_RES-1:0] t_slot_vec;

    // all results caused by one page byte, oldest in slot 0
    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_slot_vec        slots;
    } t_cmd;

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h61 + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // characters of "t10.", "eui." and "naa."
    function automatic logic [7:0] tag_char(input logic [1:0] ty, input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0: begin
                r = (ty == ID_T10) ? 8'h74 : ((ty == ID_EUI) ? 8'h65 : 8'h6e);
            end
            2'd1: begin
                r = (ty == ID_T10) ? 8'h31 : ((ty == ID_EUI) ? 8'h75 : 8'h61);
            end
            2'd2: begin
                r = (ty == ID_T10) ? 8'h30 : ((ty == ID_EUI) ? 8'h69 : 8'h61);
            end
            default: begin
                r = 8'h2e;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/vde_front.sv =====
`timescale 1ns / 1ps
// Front end: walks the page one accepted byte per cycle, building its result list.
// Depends on vde_pkg.
module vde_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  vde_pkg::t_page_in i_page,
    output vde_pkg::t_cmd     o_cmd,
    output logic              o_cmd_push
);

    logic [2:0]       r_hs,      n_hs;
    logic [2:0]       r_pos,     n_pos;
    logic [3:0]       r_code,    n_code;
    logic [7:0]       r_rem,     n_rem;
    logic             r_emits,   n_emits;
    logic             r_started, n_started;
    logic             r_spend,   n_spend;
    logic             r_stopped, n_stopped;
    logic [2:0]       r_pcnt,    n_pcnt;
    logic             r_lc,      n_lc;
    logic [3:0][7:0]  r_buf,     n_buf;

    vde_pkg::t_cmd cmd;

    function automatic vde_pkg::t_cmd add(input vde_pkg::t_cmd c, input logic [1:0] k,
                                          input logic [7:0] ch, input logic [1:0] ty);
        vde_pkg::t_cmd r;
        r = c;
        if (c.count < vde_pkg::CNT_W'(vde_pkg::MAX_RES)) begin
            r.slots[c.count] = '{kind: k, text_char: ch, id_type: ty};
            r.count          = c.count + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [1:0] cur_type(input logic [3:0] code, input logic lc,
                                            input logic [7:0] b0);
        logic [1:0] r;
        case (code)
            vde_pkg::DC_T10: r = vde_pkg::ID_T10;
            vde_pkg::DC_EUI: r = vde_pkg::ID_EUI;
            vde_pkg::DC_NAA: r = vde_pkg::ID_NAA;
            default: begin
                if (lc) begin
                    r = (b0 == 8'h65) ? vde_pkg::ID_EUI : vde_pkg::ID_NAA;
                end else begin
                    r = vde_pkg::ID_NAME;
                end
            end
        endcase
        return r;
    endfunction

    // send the bytes of a name string that never reached four bytes
    function automatic vde_pkg::t_cmd flush(input vde_pkg::t_cmd c, input logic [3:0] code,
                                            input logic stopped, input logic [2:0] cnt,
                                            input logic [3:0][7:0] bytes);
        vde_pkg::t_cmd r;
        r = c;
        if (code == vde_pkg::DC_NAME && !stopped && cnt < vde_pkg::PREFIX_LEN) begin
            for (int i = 0; i < 4; i++) begin
                if (i < int'(cnt)) begin
                    r = add(r, vde_pkg::KIND_CHAR, bytes[i], vde_pkg::ID_NAME);
                end
            end
        end
        return r;
    endfunction

    function automatic logic is_lc_prefix(input logic [3:0][7:0] p);
        return p[1] != 8'h00 && p[3] == 8'h2e &&
               ((p[0] == 8'h65 && p[1] == 8'h75 && p[2] == 8'h69) ||
                (p[0] == 8'h6e && p[1] == 8'h61 && p[2] == 8'h61));
    endfunction

    always_comb begin
        logic [7:0] b;
        logic       len_ok_eui;
        logic       len_ok_naa;
        logic [1:0] ty;

        b          = i_page.page_byte;
        cmd        = '0;
        len_ok_eui = (b == 8'd8) || (b == 8'd12) || (b == 8'd16);
        len_ok_naa = (b == 8'd8) || (b == 8'd16);
        ty         = vde_pkg::ID_T10;

        n_hs      = r_hs;
        n_pos     = r_pos;
        n_code    = r_code;
        n_rem     = r_rem;
        n_emits   = r_emits;
        n_started = r_started;
        n_spend   = r_spend;
        n_stopped = r_stopped;
        n_pcnt    = r_pcnt;
        n_lc      = r_lc;
        n_buf     = r_buf;

        if (r_hs < vde_pkg::HDR_LEN) begin
            n_hs = r_hs + 3'd1;
        end else if (r_pos < vde_pkg::POS_LEN) begin
            if (r_pos == vde_pkg::POS_CODE) begin
                n_code = b[3:0];
            end
            n_pos = r_pos + 3'd1;
        end else if (r_pos == vde_pkg::POS_LEN) begin
            // length byte: open a new descriptor
            n_started = 1'b0;
            n_spend   = 1'b0;
            n_stopped = 1'b0;
            n_pcnt    = 3'd0;
            n_lc      = 1'b0;
            n_emits   = (r_code == vde_pkg::DC_T10) ||
                        (r_code == vde_pkg::DC_EUI && len_ok_eui) ||
                        (r_code == vde_pkg::DC_NAA && len_ok_naa) ||
                        (r_code == vde_pkg::DC_NAME);
            ty        = cur_type(r_code, 1'b0, r_buf[0]);
            if (n_emits && r_code != vde_pkg::DC_NAME) begin
                for (int i = 0; i < 4; i++) begin
                    cmd = add(cmd, vde_pkg::KIND_CHAR, vde_pkg::tag_char(ty, 2'(i)), ty);
                end
            end
            if (b == 8'd0) begin
                if (n_emits) begin
                    cmd = add(cmd, vde_pkg::KIND_END, 8'd0, ty);
                end
                n_pos = 3'd0;
            end else begin
                n_rem = b;
                n_pos = vde_pkg::POS_PAYLOAD;
            end
        end else begin
            if (r_emits) begin
                case (r_code)
                    vde_pkg::DC_T10: begin
                        if (!r_stopped) begin
                            if (b == 8'd0) begin
                                n_stopped = 1'b1;
                            end else if (!(!r_started && b == 8'h20) &&
                                         !(b < 8'h20 || b > 8'h7e || b == 8'h22)) begin
                                if (b == 8'h20) begin
                                    n_spend = 1'b1;
                                end else begin
                                    if (r_spend) begin
                                        cmd     = add(cmd, vde_pkg::KIND_CHAR, 8'h5f,
                                                      vde_pkg::ID_T10);
                                        n_spend = 1'b0;
                                    end
                                    cmd       = add(cmd, vde_pkg::KIND_CHAR, b, vde_pkg::ID_T10);
                                    n_started = 1'b1;
                                end
                            end
                        end
                    end
                    vde_pkg::DC_EUI, vde_pkg::DC_NAA: begin
                        ty  = cur_type(r_code, r_lc, r_buf[0]);
                        cmd = add(cmd, vde_pkg::KIND_CHAR, vde_pkg::hex_char(b[7:4]), ty);
                        cmd = add(cmd, vde_pkg::KIND_CHAR, vde_pkg::hex_char(b[3:0]), ty);
                    end
                    default: begin
                        if (!r_stopped) begin
                            if (b == 8'd0) begin
                                cmd       = flush(cmd, r_code, r_stopped, r_pcnt, r_buf);
                                n_stopped = 1'b1;
                            end else if (r_pcnt < vde_pkg::PREFIX_LEN) begin
                                n_buf[r_pcnt[1:0]] = b;
                                n_pcnt             = r_pcnt + 3'd1;
                                if (n_pcnt == vde_pkg::PREFIX_LEN) begin
                                    n_lc = is_lc_prefix(n_buf);
                                    ty   = cur_type(r_code, n_lc, n_buf[0]);
                                    for (int i = 0; i < 4; i++) begin
                                        cmd = add(cmd, vde_pkg::KIND_CHAR, n_buf[i], ty);
                                    end
                                end
                            end else begin
                                ty  = cur_type(r_code, r_lc, r_buf[0]);
                                cmd = add(cmd, vde_pkg::KIND_CHAR,
                                          r_lc ? vde_pkg::to_lower(b) : b, ty);
                            end
                        end
                    end
                endcase
            end
            n_rem = r_rem - 8'd1;
            if (n_rem == 8'd0) begin
                if (r_emits) begin
                    cmd = flush(cmd, r_code, n_stopped, n_pcnt, n_buf);
                    cmd = add(cmd, vde_pkg::KIND_END, 8'd0, cur_type(r_code, n_lc, n_buf[0]));
                end
                n_pos = 3'd0;
            end
        end

        if (i_page.page_end) begin
            if (n_pos == vde_pkg::POS_PAYLOAD && n_emits) begin
                cmd = flush(cmd, n_code, n_stopped, n_pcnt, n_buf);
                cmd = add(cmd, vde_pkg::KIND_CUT, 8'd0, cur_type(n_code, n_lc, n_buf[0]));
            end
            // start a fresh page
            n_hs      = 3'd0;
            n_pos     = 3'd0;
            n_code    = 4'd0;
            n_rem     = 8'd0;
            n_emits   = 1'b0;
            n_started = 1'b0;
            n_spend   = 1'b0;
            n_stopped = 1'b0;
            n_pcnt    = 3'd0;
            n_lc      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs      <= 3'd0;
            r_pos     <= 3'd0;
            r_code    <= 4'd0;
            r_rem     <= 8'd0;
            r_emits   <= 1'b0;
            r_started <= 1'b0;
            r_spend   <= 1'b0;
            r_stopped <= 1'b0;
            r_pcnt    <= 3'd0;
            r_lc      <= 1'b0;
        end else if (i_accept) begin
            r_hs      <= n_hs;
            r_pos     <= n_pos;
            r_code    <= n_code;
            r_rem     <= n_rem;
            r_emits   <= n_emits;
            r_started <= n_started;
            r_spend   <= n_spend;
            r_stopped <= n_stopped;
            r_pcnt    <= n_pcnt;
            r_lc      <= n_lc;
        end
    end

    // prefix bytes are only read below the fill count
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_buf <= n_buf;
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = i_accept && (cmd.count != '0);

endmodule

// ===== rtl/vde_cmdq.sv =====
`timescale 1ns / 1ps
// Short queue of per-byte result lists between the front and back ends.
// Depends on vde_pkg.
module vde_cmdq #(
    parameter int Depth = vde_pkg::CMD_Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vde_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output vde_pkg::t_cmd o_head,
    output logic          o_valid
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    vde_pkg::t_cmd   r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt;

    always_comb begin
        n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CntW'(Depth));

endmodule

// ===== rtl/vde_back.sv =====
`timescale 1ns / 1ps
// Back end: sends result lists via an output register, one item per cycle while popped.
// Depends on vde_pkg.
module vde_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vde_pkg::t_cmd    i_head,
    input  logic             i_head_valid,
    output logic             o_head_pop,
    output vde_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);

    logic [vde_pkg::CNT_W-1:0] r_idx;
    logic                      r_valid;
    vde_pkg::t_result          r_res;
    logic                      adv;
    logic                      at_last;
    vde_pkg::t_slot            slot;

    always_comb begin
        adv        = i_head_valid && (!r_valid || i_pop);
        at_last    = (r_idx == i_head.count - 1'b1);
        slot       = i_head.slots[r_idx];
        o_head_pop = adv && at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_idx   <= at_last ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= '{kind: slot.kind, text_char: slot.text_char,
                       id_type: slot.id_type, run_last: at_last};
        end
    end

    assign o_result = r_res;
    assign o_empty  = !r_valid;

endmodule

// ===== rtl/vpd_designator_id_extractor_top.sv =====
`timescale 1ns / 1ps
// Top level of the device identification designator extractor.
// Depends on vde_pkg, vde_front, vde_cmdq and vde_back.
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  -------------------------------
//   page     in         push / full          i_page   (page_byte, page_end)
//   result   out        empty / pop          o_result (kind, text_char,
//                                                      id_type, run_last)
//
// A page byte is taken every cycle while full is low; the front end settles it in
// that cycle. Results leave the output register at one item per cycle while pop is
// high, so a byte that causes n items holds the back end until all n have left
// (two for a hex byte that does not end its descriptor). With the queue empty, the
// first item of a byte goes through the queue entry, then the output register.
// Synchronous reset clears the walk, the queue and the output register.
// full rises when the command queue holds QDepth lists, behind a stalled pop or
// when bytes that cause several items each arrive back to back.
module vpd_designator_id_extractor_top #(
    parameter int QDepth = vde_pkg::CMD_Q_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  vde_pkg::t_page_in i_page,
    output logic              empty,
    input  logic              pop,
    output vde_pkg::t_result  o_result
);

    logic          accept;
    vde_pkg::t_cmd cmd;
    logic          cmd_push;
    vde_pkg::t_cmd head;
    logic          head_valid;
    logic          head_pop;
    logic          q_full;

    assign accept = push && !q_full;
    assign full   = q_full;

    vde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_page     (i_page),
        .o_cmd      (cmd),
        .o_cmd_push (cmd_push)
    );

    vde_cmdq #(
        .Depth (QDepth)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_valid (head_valid)
    );

    vde_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule

// ===== rtl/vde_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the designator id extractor, bound to the top level.
// Depends on vde_pkg and vpd_designator_id_extractor_top.
module vde_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              push,
    input logic              full,
    input vde_pkg::t_page_in i_page,
    input logic              empty,
    input logic              pop,
    input vde_pkg::t_result  o_result
);

    // reset drains the output side
    a_reset_empty: assert property (@(posedge i_clk) $past(!i_rst_n) |-> empty)
        else $error("result waiting right after reset");

    // a waiting item holds until it is taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result changed or vanished");

    a_kind_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.kind == vde_pkg::KIND_CHAR ||
                    o_result.kind == vde_pkg::KIND_END ||
                    o_result.kind == vde_pkg::KIND_CUT))
        else $error("unused result kind");

    // an end marker closes the run of its byte and carries no character
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.kind != vde_pkg::KIND_CHAR |->
            o_result.run_last && o_result.text_char == 8'd0)
        else $error("end marker not last or has a character");

    // an accepted page byte carries no unknown bits
    a_page_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |-> !$isunknown(i_page))
        else $error("page item with unknown bits accepted");

endmodule

bind vpd_designator_id_extractor_top vde_checker u_vde_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_page   (i_page),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// ===== bench/vpd_designator_id_extractor_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for vpd_designator_id_extractor_top: directed page bytes, then random pages.
// Depends on vde_pkg and the extractor RTL; carries its own designator-walk predictor.
module vpd_designator_id_extractor_top_tb;
    import vde_pkg::*;

    typedef struct packed {
        logic [7:0]  b;
        logic        e;
        logic        typed_exp;
        logic [31:0] txt;
        logic [2:0]  ntxt;
        logic        mark;
        logic [1:0]  mark_kind;
        logic [1:0]  ty;
    } t_row;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_page_in i_page;
    logic     empty;
    logic     pop;
    t_result  o_result;

    vpd_designator_id_extractor_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_page   (i_page),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches    = 0;

    t_row     dir_rows[$];
    t_row     sent_rows[$];
    t_page_in page_q[$];
    t_result  expected_results[$];
    t_result  step_res[$];

    // walk state of the predictor
    logic [2:0] hdr_cnt     = '0;
    logic [2:0] walk_pos    = '0;
    logic [3:0] dcode       = '0;
    logic [7:0] pay_left    = '0;
    logic       desc_live   = 1'b0;
    logic       txt_started = 1'b0;
    logic       space_hold  = 1'b0;
    logic       txt_done    = 1'b0;
    logic [7:0] pfx_buf[4];
    logic [2:0] pfx_cnt     = '0;
    logic       pfx_lower   = 1'b0;

    function automatic logic [1:0] id_now();
        logic [1:0] r;
        case (dcode)
            DC_T10: r = ID_T10;
            DC_EUI: r = ID_EUI;
            DC_NAA: r = ID_NAA;
            default: begin
                if (pfx_lower) begin
                    r = (pfx_buf[0] == "e") ? ID_EUI : ID_NAA;
                end else begin
                    r = ID_NAME;
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] nib_hex(input logic [3:0] v);
        return (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h61 + {4'h0, v} - 8'd10;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] ch, input logic [1:0] ty);
        if (step_res.size() < MAX_RES) begin
            step_res.push_back({kind, ch, ty, 1'b0});
        end
    endtask

    task automatic emit_tag(input logic [31:0] tag, input logic [1:0] ty);
        for (int i = 0; i < 4; i++) begin
            emit(KIND_CHAR, tag[31-8*i -: 8], ty);
        end
    endtask

    task automatic clear_walk();
        hdr_cnt     = '0;
        walk_pos    = '0;
        dcode       = '0;
        pay_left    = '0;
        desc_live   = 1'b0;
        txt_started = 1'b0;
        space_hold  = 1'b0;
        txt_done    = 1'b0;
        pfx_cnt     = '0;
        pfx_lower   = 1'b0;
        for (int i = 0; i < 4; i++) begin
            pfx_buf[i] = '0;
        end
    endtask

    // send name bytes still held back while the prefix was undecided
    task automatic flush_pfx();
        if (dcode == DC_NAME && !txt_done && pfx_cnt < PREFIX_LEN) begin
            for (int i = 0; i < pfx_cnt; i++) begin
                emit(KIND_CHAR, pfx_buf[i], ID_NAME);
            end
        end
    endtask

    task automatic t10_char(input logic [7:0] b);
        if (!txt_done) begin
            if (b == 8'h00) begin
                txt_done = 1'b1;
            end else if (!(b < 8'h20 || b > 8'h7e || b == "\"" ||
                           (!txt_started && b == " "))) begin
                if (b == " ") begin
                    space_hold = 1'b1;
                end else begin
                    if (space_hold) begin
                        emit(KIND_CHAR, "_", ID_T10);
                        space_hold = 1'b0;
                    end
                    emit(KIND_CHAR, b, ID_T10);
                    txt_started = 1'b1;
                end
            end
        end
    endtask

    task automatic name_char(input logic [7:0] b);
        logic [31:0] pfx;
        if (!txt_done) begin
            if (b == 8'h00) begin
                flush_pfx();
                txt_done = 1'b1;
            end else if (pfx_cnt < PREFIX_LEN) begin
                pfx_buf[pfx_cnt[1:0]] = b;
                pfx_cnt = pfx_cnt + 3'd1;
                if (pfx_cnt == PREFIX_LEN) begin
                    pfx = {pfx_buf[0], pfx_buf[1], pfx_buf[2], pfx_buf[3]};
                    pfx_lower = (pfx == "eui." || pfx == "naa.");
                    emit_tag(pfx, id_now());
                end
            end else begin
                emit(KIND_CHAR, (pfx_lower && b >= "A" && b <= "Z") ? b + 8'd32 : b,
                     id_now());
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        if (hdr_cnt < HDR_LEN) begin
            hdr_cnt = hdr_cnt + 3'd1;
        end else if (walk_pos < POS_LEN) begin
            if (walk_pos == POS_CODE) begin
                dcode = b[3:0];
            end
            walk_pos = walk_pos + 3'd1;
        end else if (walk_pos == POS_LEN) begin
            desc_live   = 1'b0;
            txt_started = 1'b0;
            space_hold  = 1'b0;
            txt_done    = 1'b0;
            pfx_cnt     = '0;
            pfx_lower   = 1'b0;
            case (dcode)
                DC_T10: begin
                    desc_live = 1'b1;
                    emit_tag("t10.", ID_T10);
                end
                DC_EUI: begin
                    if (b == 8'd8 || b == 8'd12 || b == 8'd16) begin
                        desc_live = 1'b1;
                        emit_tag("eui.", ID_EUI);
                    end
                end
                DC_NAA: begin
                    if (b == 8'd8 || b == 8'd16) begin
                        desc_live = 1'b1;
                        emit_tag("naa.", ID_NAA);
                    end
                end
                DC_NAME: desc_live = 1'b1;
                default: desc_live = 1'b0;
            endcase
            if (b == 8'h00) begin
                if (desc_live) begin
                    emit(KIND_END, 8'h00, id_now());
                end
                walk_pos = '0;
            end else begin
                pay_left = b;
                walk_pos = POS_PAYLOAD;
            end
        end else begin
            if (desc_live) begin
                case (dcode)
                    DC_T10: t10_char(b);
                    DC_EUI, DC_NAA: begin
                        emit(KIND_CHAR, nib_hex(b[7:4]), id_now());
                        emit(KIND_CHAR, nib_hex(b[3:0]), id_now());
                    end
                    default: name_char(b);
                endcase
            end
            pay_left = pay_left - 8'd1;
            if (pay_left == 8'h00) begin
                if (desc_live) begin
                    flush_pfx();
                    emit(KIND_END, 8'h00, id_now());
                end
                walk_pos = '0;
            end
        end
        if (last) begin
            if (walk_pos == POS_PAYLOAD && desc_live) begin
                flush_pfx();
                emit(KIND_CUT, 8'h00, id_now());
            end
            clear_walk();
        end
    endtask

    // predict every accepted byte; typed table rows replace the prediction
    task automatic take_page_item(input t_page_in it);
        t_row r;
        r = sent_rows.pop_front();
        step_res.delete();
        predict_byte(it.page_byte, it.page_end);
        if (r.typed_exp) begin
            step_res.delete();
            for (int i = 0; i < r.ntxt; i++) begin
                emit(KIND_CHAR, r.txt[8*(r.ntxt-1-i) +: 8], r.ty);
            end
            if (r.mark) begin
                emit(r.mark_kind, 8'h00, r.ty);
            end
        end
        if (step_res.size() > 0) begin
            step_res[step_res.size()-1].run_last = 1'b1;
        end
        foreach (step_res[i]) begin
            expected_results.push_back(step_res[i]);
        end
    endtask

    task automatic report(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected kind %0d char %h type %0d last %0d,",
                     what, want.kind, want.text_char, want.id_type, want.run_last);
            $display("    got kind %0d char %h type %0d last %0d",
                     got.kind, got.text_char, got.id_type, got.run_last);
        end
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (expected_results.size() == 0) begin
            report("unexpected item", '0, got);
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.text_char !== want.text_char ||
                got.id_type !== want.id_type || got.run_last !== want.run_last) begin
                report("mismatch", want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                take_page_item(i_page);
            end
            if (pop && !empty) begin
                check_result(o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic add_plain(input logic [7:0] b, input logic e);
        dir_rows.push_back({b, e, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10});
    endtask

    task automatic add_typed(input logic [7:0] b, input logic e, input logic [31:0] txt,
                             input logic [2:0] n, input logic mark, input logic [1:0] mk,
                             input logic [1:0] ty);
        dir_rows.push_back({b, e, 1'b1, txt, n, mark, mk, ty});
    endtask

    task automatic send_row(input t_row r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        sent_rows.push_back(r);
        push   <= 1'b1;
        i_page <= {r.b, r.e};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // hold the sender until every predicted item has come out
    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0 || sent_rows.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] t10_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30) return " ";
        if (r < 35) return "\"";
        if (r < 40) return 8'h00;
        if (r < 45) return 8'($urandom_range(8'h01, 8'h1f));
        if (r < 50) return 8'($urandom_range(8'h7f, 8'hff));
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    function automatic logic [7:0] name_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 6) return 8'h00;
        if (r < 12) return 8'($urandom_range(255));
        if (r < 40) return 8'($urandom_range("A", "Z"));
        if (r < 80) return 8'($urandom_range("a", "z"));
        return 8'($urandom_range(8'h21, 8'h40));
    endfunction

    task automatic add_byte(input logic [7:0] b);
        page_q.push_back({b, 1'b0});
    endtask

    // one page: header, a few descriptors, sometimes trailing noise or a cut
    task automatic build_page(output int live);
        int          ndesc;
        int          sel;
        int          len;
        int          pfx_pick;
        int          cut;
        logic [3:0]  code;
        logic [3:0]  hi;
        logic [31:0] pfx;
        page_q.delete();
        live = 0;
        for (int i = 0; i < 4; i++) begin
            add_byte(8'($urandom_range(255)));
        end
        ndesc = $urandom_range(1, 3);
        for (int d = 0; d < ndesc; d++) begin
            sel = $urandom_range(9);
            if (sel < 3) begin
                code = DC_T10;
                len  = $urandom_range(0, 12);
            end else if (sel < 5) begin
                code = DC_EUI;
                sel  = $urandom_range(9);
                len  = (sel < 6) ? 8 : (sel < 8) ? 12 : (sel < 9) ? 16 : $urandom_range(0, 20);
            end else if (sel < 7) begin
                code = DC_NAA;
                sel  = $urandom_range(9);
                len  = (sel < 7) ? 8 : (sel < 8) ? 16 : $urandom_range(0, 20);
            end else if (sel < 9) begin
                code = DC_NAME;
                len  = $urandom_range(0, 12);
            end else begin
                do begin
                    code = 4'($urandom_range(15));
                end while (code == DC_T10 || code == DC_EUI || code == DC_NAA ||
                           code == DC_NAME);
                len = $urandom_range(0, 6);
            end
            hi = 4'($urandom_range(15));
            add_byte(8'($urandom_range(255)));
            add_byte({hi, code});
            add_byte(8'($urandom_range(255)));
            add_byte(8'(len));
            pfx_pick = $urandom_range(0, 5);
            case (pfx_pick)
                0: pfx = "eui.";
                1: pfx = "naa.";
                2: pfx = "EUI.";
                3: pfx = "nAa.";
                default: pfx = "____";
            endcase
            for (int i = 0; i < len; i++) begin
                if (code == DC_T10) begin
                    add_byte(t10_text_byte());
                end else if (code == DC_NAME) begin
                    add_byte((pfx_pick < 4 && i < 4) ? pfx[31-8*i -: 8] : name_text_byte());
                end else begin
                    add_byte(8'($urandom_range(255)));
                end
            end
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(1, page_q.size() - 1);
            while (page_q.size() > cut) void'(page_q.pop_back());
        end
        page_q[page_q.size()-1].page_end = 1'b1;
        live = page_q.size();
    endtask

    initial begin
        int       live_sent;
        int       live;
        int       phase;
        t_page_in it;
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_page  = '0;
        clear_walk();

        // header bytes are swallowed
        add_typed(8'hff, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        add_typed(8'hff, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        // vendor id with empty payload
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        add_typed(8'h01, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_T10);
        add_typed(8'h00, 1'b0, "t10.", 3'd4, 1'b1, KIND_END, ID_T10);
        // name string with empty payload
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_typed(8'h08, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b1, KIND_END, ID_NAME);
        // naa with a bad length is skipped
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAA);
        add_typed(8'h03, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAA);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAA);
        add_typed(8'h01, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAA);
        add_typed(8'hff, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAA);
        // short name string ended by a zero byte
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_typed(8'h08, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_typed(8'h03, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_NAME);
        add_plain("E", 1'b0);
        add_plain("u", 1'b0);
        add_typed(8'h00, 1'b0, "Eu", 3'd2, 1'b1, KIND_END, ID_NAME);
        // eui cut short by page end
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_EUI);
        add_typed(8'h02, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_EUI);
        add_typed(8'h00, 1'b0, 32'h0, 3'd0, 1'b0, KIND_END, ID_EUI);
        add_typed(8'h08, 1'b0, "eui.", 3'd4, 1'b0, KIND_END, ID_EUI);
        add_plain(8'ha5, 1'b0);
        add_plain(8'h3c, 1'b1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_row(dir_rows[k]);
        end
        hold_until_drained();

        live_sent = 0;
        phase     = 0;
        while (live_sent < 100) begin
            if (phase < 3 && live_sent >= 25 * (phase + 1)) begin
                phase++;
                hold_until_drained();
                send_idle_pct = (phase == 1) ? 49 : (phase == 3) ? 16 : 0;
                recv_idle_pct = (phase == 2) ? 49 : (phase == 3) ? 16 : 0;
            end
            build_page(live);
            foreach (page_q[k]) begin
                it = page_q[k];
                send_row({it.page_byte, it.page_end, 1'b0, 32'h0, 3'd0, 1'b0,
                          KIND_END, ID_T10});
            end
            live_sent += live;
        end
        push <= 1'b0;

        while (expected_results.size() != 0 || sent_rows.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("simulation failed");
        $finish;
    end

endmodule
